@@ rtl/core/sia_pkg.sv @@
// sia_pkg: types, command codes and constants for the script integer ALU.
// Used by sia_front, sia_back and script_integer_alu. No dependencies.
package sia_pkg;

	localparam int QueueDepthDef = 4;
	localparam int DataW = 32;
	localparam int DivSteps = DataW;

	localparam logic [4:0] CMD_DIV  = 5'd6;
	localparam logic [4:0] CMD_REM  = 5'd7;
	localparam logic [4:0] CMD_ADD  = 5'd8;
	localparam logic [4:0] CMD_SUB  = 5'd9;
	localparam logic [4:0] CMD_XOR  = 5'd10;
	localparam logic [4:0] CMD_OR   = 5'd11;
	localparam logic [4:0] CMD_AND  = 5'd12;
	localparam logic [4:0] CMD_EQ   = 5'd13;
	localparam logic [4:0] CMD_LOR  = 5'd14;
	localparam logic [4:0] CMD_GT   = 5'd15;
	localparam logic [4:0] CMD_LT   = 5'd16;
	localparam logic [4:0] CMD_GE   = 5'd17;
	localparam logic [4:0] CMD_LE   = 5'd18;
	localparam logic [4:0] CMD_MUL  = 5'd19;
	localparam logic [4:0] CMD_NE   = 5'd20;
	localparam logic [4:0] CMD_LAND = 5'd21;
	localparam logic [4:0] CMD_SHR  = 5'd22;
	localparam logic [4:0] CMD_SHL  = 5'd23;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_REMZ    = 2'd2;

	localparam logic [DataW-1:0] DIV_ZERO_VALUE = 32'h0FFF_FFFF;

	typedef enum logic [4:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_OR, OP_XOR, OP_AND,
		OP_SHL, OP_SHR, OP_LAND, OP_LOR, OP_EQ, OP_NE, OP_GT, OP_LT,
		OP_GE, OP_LE, OP_UNK
	} op_t;

	typedef struct packed {
		logic [4:0]              command;
		logic signed [DataW-1:0] left_operand;
		logic signed [DataW-1:0] right_operand;
	} req_word_t;

	typedef struct packed {
		logic signed [DataW-1:0] result_value;
		logic [1:0]              status;
	} rsp_word_t;

	// decoded word held in the queue
	typedef struct packed {
		op_t                     op;
		logic signed [DataW-1:0] a;
		logic signed [DataW-1:0] b;
	} dec_word_t;

	// per-stage control carried down the back pipeline
	typedef struct packed {
		op_t              op;
		logic [DataW-1:0] res;
		logic [1:0]       status;
		logic             an;
		logic             bn;
		logic             bz;
	} ctl_t;

endpackage

@@ rtl/core/script_integer_alu.sv @@
// script_integer_alu: top level; decode front, queue, execute back.
// Depends on sia_pkg, sia_front, sia_back.
//
//  channel | dir | handshake              | word
//  req     | in  | req_valid / req_stall  | req_word_t (command, operands)
//  rsp     | out | rsp_valid / rsp_stall  | rsp_word_t (result_value, status)
//
// One word per cycle sustained while rsp is not stalled. Path from acceptance to rsp_valid
// with an empty queue: the word is written to a queue slot and popped from it, then
// one execute stage, 32 divider stages (one quotient bit each), and the output register.
// Reset clears the queue and all stage valids.
// A stall on rsp while rsp_valid is high freezes the back pipeline; the queue keeps taking words until full.
module script_integer_alu import sia_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);
	logic      q_valid, q_pop;
	dec_word_t q_head;

	sia_front #(.QueueDepth(QueueDepth)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head)
	);

	sia_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ rtl/core/sia_front.sv @@
// sia_front: accepts request words, decodes the command, and queues them.
// Depends on sia_pkg.
module sia_front import sia_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      q_valid,
	input  logic      q_pop,
	output dec_word_t q_head
);
	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	dec_word_t       mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push, pop;
	op_t             op;

	always_comb begin
		case (req.command)
			CMD_ADD:  op = OP_ADD;
			CMD_SUB:  op = OP_SUB;
			CMD_MUL:  op = OP_MUL;
			CMD_DIV:  op = OP_DIV;
			CMD_REM:  op = OP_REM;
			CMD_OR:   op = OP_OR;
			CMD_XOR:  op = OP_XOR;
			CMD_AND:  op = OP_AND;
			CMD_SHL:  op = OP_SHL;
			CMD_SHR:  op = OP_SHR;
			CMD_LAND: op = OP_LAND;
			CMD_LOR:  op = OP_LOR;
			CMD_EQ:   op = OP_EQ;
			CMD_NE:   op = OP_NE;
			CMD_GT:   op = OP_GT;
			CMD_LT:   op = OP_LT;
			CMD_GE:   op = OP_GE;
			CMD_LE:   op = OP_LE;
			default:  op = OP_UNK;
		endcase
	end

	assign req_stall = (count_q == CntW'(QueueDepth));
	assign push      = req_valid && !req_stall;
	assign q_valid   = (count_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{op: op, a: req.left_operand, b: req.right_operand};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QueueDepth)) else $error("queue count overflow");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("push lost");
	a_count_dn: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1) else $error("pop lost");

endmodule

@@ rtl/core/sia_back.sv @@
// sia_back: executes decoded words; one-bit-per-stage divider pipeline plus
// output register. Depends on sia_pkg.
module sia_back import sia_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_pop,
	input  dec_word_t q_head,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);
	logic             adv;
	logic             vld_s [DivSteps+1];
	ctl_t             ctl_s [DivSteps+1];
	logic [DataW-1:0] rem_s [DivSteps+1];
	logic [DataW-1:0] quo_s [DivSteps+1];
	logic [DataW-1:0] num_s [DivSteps+1];
	logic [DataW-1:0] dv_s  [DivSteps+1];
	logic             out_valid_q;
	rsp_word_t        out_q;

	ctl_t             ctl_in;
	logic [DataW-1:0] a, b, mag_a, mag_b;
	logic [4:0]       sh;
	ctl_t             ctl_end;
	logic [DataW-1:0] fin;

	// whole pipeline moves together; the queue absorbs the stall
	assign adv   = !out_valid_q || !rsp_stall;
	assign q_pop = adv && q_valid;

	always_comb begin
		a     = q_head.a;
		b     = q_head.b;
		sh    = b[4:0];
		mag_a = a[DataW-1] ? (~a + 1'b1) : a;
		mag_b = b[DataW-1] ? (~b + 1'b1) : b;
		ctl_in.op     = q_head.op;
		ctl_in.an     = a[DataW-1];
		ctl_in.bn     = b[DataW-1];
		ctl_in.bz     = (b == '0);
		ctl_in.status = ST_OK;
		case (q_head.op)
			OP_ADD:  ctl_in.res = a + b;
			OP_SUB:  ctl_in.res = a - b;
			OP_MUL:  ctl_in.res = a * b;
			OP_OR:   ctl_in.res = a | b;
			OP_XOR:  ctl_in.res = a ^ b;
			OP_AND:  ctl_in.res = a & b;
			OP_SHL:  ctl_in.res = a << sh;
			OP_SHR:  ctl_in.res = $signed(q_head.a) >>> sh;
			OP_LAND: ctl_in.res = DataW'((a != '0) && (b != '0));
			OP_LOR:  ctl_in.res = DataW'((a != '0) || (b != '0));
			OP_EQ:   ctl_in.res = DataW'(a == b);
			OP_NE:   ctl_in.res = DataW'(a != b);
			OP_GT:   ctl_in.res = DataW'(q_head.a > q_head.b);
			OP_LT:   ctl_in.res = DataW'(q_head.a < q_head.b);
			OP_GE:   ctl_in.res = DataW'(q_head.a >= q_head.b);
			OP_LE:   ctl_in.res = DataW'(q_head.a <= q_head.b);
			OP_DIV, OP_REM: ctl_in.res = '0;
			default: begin
				ctl_in.res    = a;
				ctl_in.status = ST_UNKNOWN;
			end
		endcase
		if (q_head.op == OP_REM && ctl_in.bz) begin
			ctl_in.status = ST_REMZ;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s[0] <= ctl_in;
			rem_s[0] <= '0;
			quo_s[0] <= '0;
			num_s[0] <= mag_a;
			dv_s[0]  <= mag_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= q_valid;
		end
	end

	// restoring divide, one quotient bit per stage, MSB first
	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		logic [DataW:0] shr_rem, dif;
		logic           ge;

		always_comb begin
			shr_rem = {rem_s[k], num_s[k][DataW-1]};
			dif     = shr_rem - {1'b0, dv_s[k]};
			ge      = !dif[DataW];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_s[k+1] <= ctl_s[k];
				rem_s[k+1] <= ge ? dif[DataW-1:0] : shr_rem[DataW-1:0];
				quo_s[k+1] <= {quo_s[k][DataW-2:0], ge};
				num_s[k+1] <= {num_s[k][DataW-2:0], 1'b0};
				dv_s[k+1]  <= dv_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	always_comb begin
		ctl_end = ctl_s[DivSteps];
		case (ctl_end.op)
			OP_DIV: begin
				if (ctl_end.bz) begin
					fin = DIV_ZERO_VALUE;
				end else begin
					fin = (ctl_end.an != ctl_end.bn) ? (~quo_s[DivSteps] + 1'b1)
						: quo_s[DivSteps];
				end
			end
			OP_REM: begin
				if (ctl_end.bz) begin
					fin = '0;
				end else begin
					fin = ctl_end.an ? (~rem_s[DivSteps] + 1'b1) : rem_s[DivSteps];
				end
			end
			default: fin = ctl_end.res;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.result_value <= fin;
			out_q.status       <= ctl_end.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[DivSteps];
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_remz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_REMZ |-> out_q.result_value == '0)
		else $error("remainder by zero gave nonzero word");
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rsp_stall |=> $stable(vld_s[DivSteps]))
		else $error("pipeline moved under stall");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed");

endmodule

@@ tb/script_integer_alu_tb.sv @@
// script_integer_alu_tb: self-checking testbench for the script integer ALU.
// Depends on sia_pkg and script_integer_alu; predicts every result word and compares in order.
`timescale 1ns / 1ps

module script_integer_alu_tb;
	import sia_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int Latency = 35;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	rsp_word_t expected_q[$];
	int        mismatches;
	int        cycles;
	bit        rsp_stall_enable;

	script_integer_alu DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// magnitude of a two's complement word
	function automatic logic [31:0] magnitude(logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic rsp_word_t alu_predict(req_word_t w);
		rsp_word_t r;
		logic [31:0] a, b, q;
		logic [4:0] sh;
		a = w.left_operand;
		b = w.right_operand;
		sh = b[4:0];
		r.status = ST_OK;
		r.result_value = '0;
		case (w.command)
			CMD_ADD: r.result_value = a + b;
			CMD_SUB: r.result_value = a - b;
			CMD_MUL: r.result_value = a * b;
			CMD_DIV: begin
				if (b == 0) r.result_value = DIV_ZERO_VALUE;
				else begin
					q = magnitude(a) / magnitude(b);
					r.result_value = (a[31] != b[31]) ? (32'd0 - q) : q;
				end
			end
			CMD_REM: begin
				if (b == 0) r.status = ST_REMZ;
				else begin
					q = magnitude(a) % magnitude(b);
					r.result_value = a[31] ? (32'd0 - q) : q;
				end
			end
			CMD_OR:   r.result_value = a | b;
			CMD_XOR:  r.result_value = a ^ b;
			CMD_AND:  r.result_value = a & b;
			CMD_SHL:  r.result_value = a << sh;
			CMD_SHR:  r.result_value = $signed(a) >>> sh;
			CMD_LAND: r.result_value = {31'd0, (a != 0) && (b != 0)};
			CMD_LOR:  r.result_value = {31'd0, (a != 0) || (b != 0)};
			CMD_LT:   r.result_value = {31'd0, $signed(a) < $signed(b)};
			CMD_LE:   r.result_value = {31'd0, $signed(a) <= $signed(b)};
			CMD_GT:   r.result_value = {31'd0, $signed(a) > $signed(b)};
			CMD_GE:   r.result_value = {31'd0, $signed(a) >= $signed(b)};
			CMD_EQ:   r.result_value = {31'd0, a == b};
			CMD_NE:   r.result_value = {31'd0, a != b};
			default: begin
				r.result_value = a;
				r.status = ST_UNKNOWN;
			end
		endcase
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input req_word_t w, input bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_q.push_back(alu_predict(w));
		@(negedge clk);
	endtask

	task automatic idle_req();
		req_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'd0;
			4: return $urandom_range(0, 40);
			5: return -$urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		req_word_t w;
		w.command = CMD_DIV; w.left_operand = 32'sd100; w.right_operand = 0;
		send_word(w, 0);
		w.command = CMD_REM; send_word(w, 0);
		w.command = CMD_DIV; w.left_operand = 32'h8000_0000; w.right_operand = -1;
		send_word(w, 0);
		w.command = CMD_REM; send_word(w, 0);
		w.command = CMD_DIV; w.left_operand = -7; w.right_operand = 2; send_word(w, 0);
		w.command = CMD_REM; send_word(w, 0);
		w.command = 5'd0; w.left_operand = 32'h1234_5678; send_word(w, 0);
		w.command = 5'd31; w.left_operand = 32'h8000_0000; send_word(w, 0);
		w.command = CMD_SHL; w.left_operand = -1; w.right_operand = 32'hFFFF_FFE1;
		send_word(w, 0);
		w.command = CMD_SHR; w.left_operand = 32'h8000_0000; w.right_operand = 31;
		send_word(w, 0);
		w.right_operand = 32; send_word(w, 0);
		w.command = CMD_ADD; w.left_operand = 32'h7FFF_FFFF; w.right_operand = 1;
		send_word(w, 0);
		w.command = CMD_SUB; w.left_operand = 32'h8000_0000; send_word(w, 0);
		w.command = CMD_MUL; w.left_operand = 32'h8000_0000; w.right_operand = -1;
		send_word(w, 0);
		for (int c = int'(CMD_XOR); c <= int'(CMD_NE); c++) begin
			if (c == int'(CMD_MUL)) continue;
			w.command = c[4:0];
			w.left_operand = 32'h8000_0000;
			w.right_operand = 32'h7FFF_FFFF;
			send_word(w, 0);
		end
		w.command = CMD_LAND; w.left_operand = 0; w.right_operand = 5; send_word(w, 0);
		idle_req();
	endtask

	task automatic test_random(input int n);
		req_word_t w;
		for (int i = 0; i < n; i++) begin
			w.command = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(6, 23));
			w.left_operand = pick_operand();
			w.right_operand = pick_operand();
			send_word(w, 1);
		end
		idle_req();
	endtask

	// send divide words, hold off until the pipeline has drained completely, then send random words
	task automatic test_drain_pause();
		req_word_t w;
		for (int i = 0; i < 20; i++) begin
			w.command = CMD_DIV;
			w.left_operand = $urandom;
			w.right_operand = pick_operand();
			send_word(w, 0);
		end
		idle_req();
		while (expected_q.size() != 0) @(negedge clk);
		test_random(30);
	endtask

	// response side: random stall when enabled, check each accepted word
	always @(negedge clk) begin
		if (!rsp_stall_enable) rsp_stall <= 1'b0;
		else rsp_stall <= (gap_len() != 0);
	end

	always @(posedge clk) begin
		rsp_word_t exp_w;
		cycles <= cycles + 1;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", rsp);
			end else begin
				exp_w = expected_q.pop_front();
				if (rsp.result_value !== exp_w.result_value || rsp.status !== exp_w.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: value exp %h got %h, status exp %0d got %0d",
							exp_w.result_value, rsp.result_value, exp_w.status, rsp.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("script_integer_alu test failed");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycles = 0;
		rsp_stall_enable = 1'b0;
		rsp_stall = 1'b0;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		rsp_stall_enable = 1'b1;
		test_random(300);
		test_drain_pause();
		rsp_stall_enable = 1'b0;
		test_random(100);
		rsp_stall_enable = 1'b1;
		test_random(250);
		while (expected_q.size() != 0) @(negedge clk);
		repeat (Latency * 2) @(negedge clk);
		if (mismatches == 0 && expected_q.size() == 0) $display("script_integer_alu test passed");
		else $display("script_integer_alu test failed");
		$finish;
	end

endmodule
